// ===== src/c2dv_pkg.sv =====
package c2dv_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_FS      = 5;
  localparam int MAX_FILTERS = 8;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 8;
  localparam int DIM_W  = 9;
  localparam int FS_W   = 3;
  localparam int CNT_W  = 4;
  localparam int FILT_W = 3;
  localparam int PIX_W  = 16;

  localparam int LINE_ROWS  = MAX_FS - 1;
  localparam int PROD_W     = 32;
  localparam int ROWSUM_W   = 35;
  localparam int SUM_W      = 36;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FSIZE  = 2'd2;
  localparam logic [1:0] REG_FCOUNT = 2'd3;

  // Input word kinds.
  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_PIXEL  = 1'b1;

  typedef struct packed {
    logic              take_weight;
    logic              take_pixel;
    logic              update;
    logic              issue;
    logic [FILT_W-1:0] filt;
    logic              last_run;
  } c2dv_cmd_t;

  typedef struct packed {
    logic win_done;
    logic credit_ok;
  } c2dv_sts_t;

endpackage

// ===== src/c2dv_ram.sv =====
module c2dv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/c2dv_ctrl.sv =====
module c2dv_ctrl import c2dv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  input  logic [CNT_W-1:0] cnt,
  input  c2dv_sts_t        sts,
  output c2dv_cmd_t        cmd
);

  typedef enum logic [1:0] {IDLE, LOAD, FILT} state_t;

  state_t            state;
  logic [FILT_W-1:0] filt;
  logic              last_run;

  assign in_ready = (state == IDLE);
  assign last_run = (({1'b0, filt} + CNT_W'(1)) == cnt);

  always_comb begin
    cmd             = '0;
    cmd.take_weight = in_ready && in_valid && (in_kind == REQ_WEIGHT);
    cmd.take_pixel  = in_ready && in_valid && (in_kind == REQ_PIXEL);
    cmd.update      = (state == LOAD);
    cmd.issue       = (state == FILT) && sts.credit_ok;
    cmd.filt        = filt;
    cmd.last_run    = last_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      filt  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.take_pixel) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          filt <= '0;
          if (sts.win_done) begin
            state <= FILT;
          end else begin
            state <= IDLE;
          end
        end
        FILT: begin
          if (sts.credit_ok) begin
            if (last_run) begin
              state <= IDLE;
            end else begin
              filt <= filt + FILT_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/c2dv_dp.sv =====
module c2dv_dp import c2dv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  c2dv_cmd_t        cmd,
  input  logic [31:0]      in_data,
  input  logic [FS_W-1:0]  fs,
  input  logic [DIM_W-1:0] w,
  input  logic [DIM_W-1:0] h,
  output c2dv_sts_t        sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [55:0]      out_data,
  output logic             out_last,
  output logic             out_flag
);

  typedef struct packed {
    logic              last_img;
    logic              last_run;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [FILT_W-1:0] f;
  } meta_t;

  typedef struct packed {
    logic              last_img;
    logic              last_run;
    logic [31:0]       val;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [FILT_W-1:0] f;
  } entry_t;

  logic [2:0]              wf, wr, wc;
  logic signed [PIX_W-1:0] sample;

  assign wf     = in_data[2:0];
  assign wr     = in_data[5:3];
  assign wc     = in_data[8:6];
  assign sample = in_data[24:9];

  // Raster position.
  logic [COL_W-1:0] pixel_col, cur_c;
  logic [ROW_W-1:0] pixel_row, cur_r;
  logic [DIM_W-1:0] col_a, row_a, nc, nr;

  always_comb begin
    col_a = {1'b0, pixel_col};
    row_a = {1'b0, pixel_row};
    if (col_a >= w) begin
      col_a = '0;
      row_a = row_a + DIM_W'(1);
    end
    if (row_a >= h) begin
      row_a = '0;
    end
    cur_c = col_a[COL_W-1:0];
    cur_r = row_a[ROW_W-1:0];
    nc    = {1'b0, cur_c} + DIM_W'(1);
    nr    = {1'b0, cur_r};
    if (nc >= w) begin
      nc = '0;
      nr = nr + DIM_W'(1);
      if (nr >= h) begin
        nr = '0;
      end
    end
  end

  logic [COL_W-1:0]        pix_c;
  logic [ROW_W-1:0]        pix_r;
  logic signed [PIX_W-1:0] pix_v;
  logic [FS_W-1:0]         fs_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0;
      pixel_row <= '0;
    end else if (cmd.take_pixel) begin
      pixel_col <= nc[COL_W-1:0];
      pixel_row <= nr[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      pix_c  <= cur_c;
      pix_r  <= cur_r;
      pix_v  <= sample;
      fs_cur <= fs;
    end
  end

  // Window completion and output position, valid during LOAD.
  logic [DIM_W-1:0] r1, c1;
  assign r1 = {1'b0, pix_r} + DIM_W'(1);
  assign c1 = {1'b0, pix_c} + DIM_W'(1);
  assign sts.win_done = (r1 >= DIM_W'(fs_cur)) && (c1 >= DIM_W'(fs_cur));

  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;
  logic             last_img;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      orow     <= ROW_W'(r1 - DIM_W'(fs_cur));
      ocol     <= COL_W'(c1 - DIM_W'(fs_cur));
      last_img <= (r1 == h) && (c1 == w);
    end
  end

  // Line store: one RAM per buffered row, each a shift stage per column.
  logic [PIX_W-1:0] line_rd [LINE_ROWS];
  logic [PIX_W-1:0] colv [MAX_FS];

  assign colv[0] = pix_v;

  for (genvar j = 0; j < LINE_ROWS; j++) begin : g_line
    logic             lwe;
    logic [PIX_W-1:0] lwd;
    assign colv[j+1] = line_rd[j];
    assign lwe = cmd.update && ((j + 2) <= int'(fs_cur));
    if (j == 0) begin : g_first
      assign lwd = pix_v;
    end else begin : g_next
      assign lwd = line_rd[j-1];
    end
    c2dv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (lwe),
      .waddr (pix_c),
      .wdata (lwd),
      .raddr (cur_c),
      .rdata (line_rd[j])
    );
  end

  // Window registers, shifted left with the new column entering at fs-1.
  logic signed [PIX_W-1:0] win [MAX_FS][MAX_FS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ii = 0; ii < MAX_FS; ii++) begin
        for (int jj = 0; jj < MAX_FS; jj++) begin
          win[ii][jj] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int ii = 0; ii < MAX_FS; ii++) begin
        for (int jj = 0; jj < MAX_FS; jj++) begin
          if (ii < int'(fs_cur)) begin
            if (jj + 1 < int'(fs_cur)) begin
              win[ii][jj] <= win[ii][jj+1];
            end else if (jj + 1 == int'(fs_cur)) begin
              win[ii][jj] <= colv[fs_cur - FS_W'(ii) - FS_W'(1)];
            end
          end
        end
      end
    end
  end

  // Weight store: one small RAM per tap, addressed by filter.
  logic signed [PIX_W-1:0] wt [MAX_FS][MAX_FS];

  for (genvar ti = 0; ti < MAX_FS; ti++) begin : g_wr
    for (genvar tj = 0; tj < MAX_FS; tj++) begin : g_wc
      logic wwe;
      assign wwe = cmd.take_weight && (wr == FS_W'(ti)) && (wc == FS_W'(tj));
      c2dv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_FILTERS)) u_wt (
        .clk   (clk),
        .we    (wwe),
        .waddr (wf),
        .wdata (sample),
        .raddr (cmd.filt),
        .rdata (wt[ti][tj])
      );
    end
  end

  // Filter pipeline: weights read, products, row sums, total.
  logic  s1_v, s2_v, s3_v;
  meta_t s1_m, s2_m, s3_m;
  logic signed [PROD_W-1:0]   prod [MAX_FS][MAX_FS];
  logic signed [ROWSUM_W-1:0] rsum [MAX_FS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_m <= '{last_img: last_img, last_run: cmd.last_run, c: ocol, r: orow, f: cmd.filt};
    s2_m <= s1_m;
    s3_m <= s2_m;
    for (int ii = 0; ii < MAX_FS; ii++) begin
      for (int jj = 0; jj < MAX_FS; jj++) begin
        if ((ii < int'(fs_cur)) && (jj < int'(fs_cur))) begin
          prod[ii][jj] <= win[ii][jj] * wt[ii][jj];
        end else begin
          prod[ii][jj] <= '0;
        end
      end
    end
    for (int ii = 0; ii < MAX_FS; ii++) begin
      rsum[ii] <= ROWSUM_W'(prod[ii][0]) + ROWSUM_W'(prod[ii][1]) + ROWSUM_W'(prod[ii][2])
                + ROWSUM_W'(prod[ii][3]) + ROWSUM_W'(prod[ii][4]);
    end
  end

  logic signed [SUM_W-1:0] total;
  logic [31:0]             sat;

  always_comb begin
    total = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2])
          + SUM_W'(rsum[3]) + SUM_W'(rsum[4]);
    if ((total[SUM_W-1:31] == '0) || (total[SUM_W-1:31] == '1)) begin
      sat = total[31:0];
    end else if (total[SUM_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  // Result FIFO; slots are reserved at issue so it cannot overflow.
  entry_t             fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head, tail;
  logic [FIFO_CW-1:0] count, used;
  logic               push, pop;
  entry_t             hd;

  assign push          = s3_v;
  assign pop           = out_valid && out_ready;
  assign out_valid     = (count != '0);
  assign hd            = fifo[head];
  assign out_data      = {5'd0, hd.val, hd.c, hd.r, hd.f};
  assign out_last      = hd.last_run;
  assign out_flag      = hd.last_img;
  assign sts.credit_ok = (used < FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[tail] <= '{last_img: s3_m.last_img, last_run: s3_m.last_run, val: sat,
                      c: s3_m.c, r: s3_m.r, f: s3_m.f};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      used  <= '0;
    end else begin
      if (push) begin
        tail <= tail + FIFO_AW'(1);
      end
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
      used  <= used + FIFO_CW'(cmd.issue) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("result FIFO overflow");

  a_credit_cover: assert property (@(posedge clk) disable iff (rst)
    used >= count)
    else $error("reserved slots fewer than stored words");

  a_issue_credit: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> used < FIFO_CW'(FIFO_DEPTH))
    else $error("filter issued without a free slot");

endmodule

// ===== src/conv2d_valid_multi_filter.sv =====
// A pixel that completes a window gives one result word for each filter in use; the
// filters issue one per cycle while a result FIFO slot is free, and each passes through
// the weight read, product and row sum registers into the result FIFO. Input words are
// accepted only while the controller is idle, so a new word waits for the last pixel.
// Reset (rst, synchronous, active high) restores the register defaults, clears the
// window registers and the raster position; line and weight stores are not cleared.
module conv2d_valid_multi_filter import c2dv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // weight_filter[2:0], weight_row[5:3], weight_col[8:6], sample_value[24:9], zeros
  input  logic [31:0] s_tdata,
  // req_type
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // filter_index[2:0], out_row[10:3], out_col[18:11], conv_value[50:19], zeros
  output logic [55:0] m_tdata,
  // last_of_run
  output logic        m_tlast,
  // last_of_image
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // Configuration registers as written.
  logic [DIM_W-1:0] image_width, image_height;
  logic [FS_W-1:0]  filter_size;
  logic [CNT_W-1:0] filter_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(MAX_WIDTH);
      image_height <= DIM_W'(MAX_HEIGHT);
      filter_size  <= FS_W'(3);
      filter_count <= CNT_W'(MAX_FILTERS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_FSIZE:  filter_size  <= cfg_data[FS_W-1:0];
        REG_FCOUNT: filter_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clamped into their legal ranges.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [FS_W-1:0]  fs_eff;
  logic [CNT_W-1:0] cnt_eff;

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = image_height;
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
    fs_eff = filter_size;
    if (filter_size == '0) begin
      fs_eff = FS_W'(1);
    end else if (filter_size > FS_W'(MAX_FS)) begin
      fs_eff = FS_W'(MAX_FS);
    end
    cnt_eff = filter_count;
    if (filter_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (filter_count > CNT_W'(MAX_FILTERS)) begin
      cnt_eff = CNT_W'(MAX_FILTERS);
    end
  end

  c2dv_cmd_t cmd;
  c2dv_sts_t sts;

  // The controller sequences each word: a pixel updates the line store and window in
  // LOAD, then, if it completes a window, issues the filters one per cycle while credit lasts.
  c2dv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .cnt      (cnt_eff),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the stores, the tap array pipeline and the result FIFO.
  c2dv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_tdata),
    .fs        (fs_eff),
    .w         (w_eff),
    .h         (h_eff),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_flag  (m_tuser)
  );

endmodule
